[rtl/kmh_pkg.sv]
// Shared types, constants and keymap lookup for the key matrix to HID report block.
package kmh_pkg;

  // Field widths of one row item and of one report
  localparam int ROW_W    = 3;
  localparam int SAMPLE_W = 18;
  localparam int IN_W     = 40;
  localparam int CODE_W   = 8;
  localparam int OUT_W    = 56;

  // Matrix geometry and report size
  localparam int ROWS      = 6;
  localparam int COLUMNS   = 18;
  localparam int KEY_SLOTS = 6;
  localparam int OUT_SLOTS = 6;
  localparam int ROM_ROWS  = 6;
  localparam int ROM_COLS  = 18;

  // Columns actually scanned and the widths that follow from them
  localparam int SCAN_COLS = (COLUMNS < ROM_COLS) ? COLUMNS : ROM_COLS;
  localparam int COL_W     = (SCAN_COLS > 1) ? $clog2(SCAN_COLS) : 1;
  localparam int FILL_W    = $clog2(KEY_SLOTS + 1);

  // Modifier usage range 0xE0 to 0xE7
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } kmh_state_t;

  // Column shifter status
  typedef struct packed {
    logic             bit_set;
    logic [COL_W-1:0] col;
    logic             last;
  } kmh_col_t;

  // Control from the sequencer to the report builder
  typedef struct packed {
    logic              clear;
    logic              add;
    logic [CODE_W-1:0] code;
    logic              check;
  } kmh_ctrl_t;

  // Status from the report builder
  typedef struct packed {
    logic done;
  } kmh_stat_t;

  localparam logic [CODE_W-1:0] KEYMAP [ROM_ROWS][ROM_COLS] = '{
    '{8'h29, 8'h3E, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
      8'h41, 8'h2D, 8'h2E, 8'h42, 8'h43, 8'h44, 8'h45, 8'h00, 8'h46},
    '{8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
      8'h26, 8'h27, 8'h2A, 8'h4A, 8'h4B, 8'h53, 8'h54, 8'h55, 8'h56},
    '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
      8'h12, 8'h13, 8'h28, 8'h4D, 8'h4E, 8'h5F, 8'h60, 8'h61, 8'h57},
    '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E,
      8'h0F, 8'h33, 8'h28, 8'h49, 8'h00, 8'h5C, 8'h5D, 8'h5E, 8'h57},
    '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36,
      8'h37, 8'h38, 8'hE5, 8'h4C, 8'h52, 8'h59, 8'h5A, 8'h5B, 8'h58},
    '{8'hE0, 8'hE3, 8'hE2, 8'hE4, 8'h2C, 8'h00, 8'h00, 8'h2C, 8'h34,
      8'h2F, 8'h30, 8'h31, 8'h50, 8'h51, 8'h4F, 8'h62, 8'h63, 8'h58}
  };

  // Usage code of one matrix position, zero outside the keymap
  function automatic logic [CODE_W-1:0] keymap_code(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
    logic [CODE_W-1:0] code;
    code = '0;
    if (32'(row) < ROM_ROWS && 32'(col) < ROM_COLS) begin
      code = KEYMAP[row][col];
    end
    return code;
  endfunction

endpackage

[rtl/key_matrix_to_hid_report.sv]
// Top level: key matrix row scanner that builds HID boot keyboard reports.
//
// One transfer on the s_ side is one scanned matrix row. A row whose two
// samples are both nonzero is decoded one column per cycle through the
// column shifter, and no further row is accepted until its last column is
// done; a row with a zero sample is not decoded. After the last row the
// check state compares the working report with the last report sent and,
// if they differ, loads it into the output stage. Decoding may go on
// while the output stage still holds an earlier report. Rows beyond the
// last are accepted and dropped. The comparison waits while an unsent
// report still occupies the output stage.
module key_matrix_to_hid_report (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata: row_index, first_sample, second_sample
  input  logic [kmh_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata: modifier_bits, key_one, key_two, key_three, key_four, key_five, key_six
  output logic [kmh_pkg::OUT_W-1:0]  m_tdata
);
  import kmh_pkg::*;

  kmh_state_t          state;
  kmh_state_t          state_next;
  logic [ROW_W-1:0]    row;
  logic                last_row;
  logic [ROW_W-1:0]    in_row;
  logic [SAMPLE_W-1:0] in_first;
  logic [SAMPLE_W-1:0] in_second;
  logic                accept;
  logic                row_ok;
  logic                used;
  logic                in_last;
  kmh_col_t            col_st;
  kmh_ctrl_t           ctrl;
  kmh_stat_t           rep_st;

  // Unpack the row transfer
  assign in_row    = s_tdata[ROW_W-1:0];
  assign in_first  = s_tdata[ROW_W +: SAMPLE_W];
  assign in_second = s_tdata[ROW_W+SAMPLE_W +: SAMPLE_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign row_ok   = (32'(in_row) < ROWS);
  assign used     = (in_first != '0) && (in_second != '0);
  assign in_last  = (32'(in_row) == ROWS - 1);

  // Hold the row being decoded
  always_ff @(posedge clk) begin
    if (accept) begin
      row      <= in_row;
      last_row <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence accept, column scan and report check
  always_comb begin
    state_next = state;
    ctrl.clear = accept && row_ok && (in_row == '0);
    ctrl.add   = 1'b0;
    ctrl.code  = keymap_code(row, col_st.col);
    ctrl.check = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && row_ok) begin
          if (used) begin
            state_next = ST_SCAN;
          end else if (in_last) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_SCAN: begin
        ctrl.add = col_st.bit_set;
        if (col_st.last) begin
          state_next = last_row ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        ctrl.check = 1'b1;
        if (rep_st.done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  kmh_col_shift u_col_shift (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .en     (state == ST_SCAN),
    .sample (in_second),
    .status (col_st)
  );

  kmh_report u_report (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .status   (rep_st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[rtl/kmh_col_shift.sv]
// Column shifter: presents one column bit of the row sample per enabled cycle.
module kmh_col_shift (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           en,
  input  logic [kmh_pkg::SAMPLE_W-1:0]   sample,
  output kmh_pkg::kmh_col_t              status
);
  import kmh_pkg::*;

  logic [SCAN_COLS-1:0] shift;
  logic [COL_W-1:0]     col;

  // Load the sample, then advance one column per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (load) begin
      col <= '0;
    end else if (en) begin
      col <= col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift <= sample[SCAN_COLS-1:0];
    end else if (en) begin
      shift <= shift >> 1;
    end
  end

  assign status.bit_set = shift[0];
  assign status.col     = col;
  assign status.last    = (32'(col) == SCAN_COLS - 1);

endmodule

[rtl/kmh_report.sv]
// Report builder: working report, last report sent and the output stream stage.
module kmh_report (
  input  logic                          clk,
  input  logic                          rst,
  input  kmh_pkg::kmh_ctrl_t            ctrl,
  output kmh_pkg::kmh_stat_t            status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: modifier_bits, key_one, key_two, key_three, key_four, key_five, key_six
  output logic [kmh_pkg::OUT_W-1:0]     m_tdata
);
  import kmh_pkg::*;

  logic [CODE_W-1:0] work_mod;
  logic [CODE_W-1:0] work_slots [OUT_SLOTS];
  logic [FILL_W-1:0] fill;
  logic [CODE_W-1:0] sent_mod;
  logic [CODE_W-1:0] sent_slots [OUT_SLOTS];
  logic              is_mod;
  logic              changed;
  logic              can_load;
  logic              load;

  assign is_mod = (ctrl.code[7:3] == MOD_PREFIX);

  // Update the working report: clear, set a modifier bit or fill the next slot
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      work_mod <= '0;
      fill     <= '0;
      for (int s = 0; s < OUT_SLOTS; s++) begin
        work_slots[s] <= '0;
      end
    end else if (ctrl.add && ctrl.code != '0) begin
      if (is_mod) begin
        work_mod[ctrl.code[2:0]] <= 1'b1;
      end else if (32'(fill) < KEY_SLOTS) begin
        fill <= fill + FILL_W'(1);
        for (int s = 0; s < OUT_SLOTS; s++) begin
          if (32'(fill) == s) begin
            work_slots[s] <= ctrl.code;
          end
        end
      end
    end
  end

  // Compare the working report with the last one sent
  always_comb begin
    changed = (work_mod != sent_mod);
    for (int s = 0; s < OUT_SLOTS; s++) begin
      if (work_slots[s] != sent_slots[s]) begin
        changed = 1'b1;
      end
    end
  end

  assign can_load    = !m_tvalid || m_tready;
  assign status.done = ctrl.check && can_load;
  assign load        = status.done && changed;

  // Hold the last report sent; it doubles as the output data
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_mod <= '0;
      for (int s = 0; s < OUT_SLOTS; s++) begin
        sent_slots[s] <= '0;
      end
    end else if (load) begin
      sent_mod   <= work_mod;
      sent_slots <= work_slots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[CODE_W-1:0] = sent_mod;
    for (int s = 0; s < OUT_SLOTS; s++) begin
      m_tdata[CODE_W*(s+1) +: CODE_W] = sent_slots[s];
    end
  end

  a_fill_range : assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= KEY_SLOTS)
    else $error("slot fill count beyond the slot count");

  a_clear : assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (fill == '0 && work_mod == '0))
    else $error("working report not cleared");

  a_load : assert property (@(posedge clk) disable iff (rst)
    load |=> (m_tvalid && !changed))
    else $error("report transfer not presented or sent copy differs");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the key matrix to HID report block.
`timescale 1ns / 100ps

module tb_top;

  // Matrix geometry and usage codes as the report is built
  localparam int ROW_COUNT    = 6;
  localparam int COL_COUNT    = 18;
  localparam int SLOT_COUNT   = 6;
  localparam logic [7:0] MOD_LOW  = 8'hE0;
  localparam logic [7:0] MOD_HIGH = 8'hE7;
  localparam logic [17:0] ALL_COLUMNS = 18'h3FFFF;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic [7:0] USAGE_MAP [ROW_COUNT][COL_COUNT] = '{
    '{8'h29, 8'h3E, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
      8'h41, 8'h2D, 8'h2E, 8'h42, 8'h43, 8'h44, 8'h45, 8'h00, 8'h46},
    '{8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
      8'h26, 8'h27, 8'h2A, 8'h4A, 8'h4B, 8'h53, 8'h54, 8'h55, 8'h56},
    '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
      8'h12, 8'h13, 8'h28, 8'h4D, 8'h4E, 8'h5F, 8'h60, 8'h61, 8'h57},
    '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E,
      8'h0F, 8'h33, 8'h28, 8'h49, 8'h00, 8'h5C, 8'h5D, 8'h5E, 8'h57},
    '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36,
      8'h37, 8'h38, 8'hE5, 8'h4C, 8'h52, 8'h59, 8'h5A, 8'h5B, 8'h58},
    '{8'hE0, 8'hE3, 8'hE2, 8'hE4, 8'h2C, 8'h00, 8'h00, 8'h2C, 8'h34,
      8'h2F, 8'h30, 8'h31, 8'h50, 8'h51, 8'h4F, 8'h62, 8'h63, 8'h58}
  };

  // Builds the expected reports from accepted rows and checks the sent ones
  class hid_report_board;
    logic [7:0] work_mods;
    logic [7:0] work_keys [SLOT_COUNT];
    logic [7:0] sent_mods;
    logic [7:0] sent_keys [SLOT_COUNT];
    logic [kmh_pkg::OUT_W-1:0] pending_reports [$];
    int errors;

    function new();
      work_mods = '0;
      sent_mods = '0;
      foreach (work_keys[s]) begin
        work_keys[s] = '0;
        sent_keys[s] = '0;
      end
      errors = 0;
    endfunction

    // Fold one accepted row into the working report
    function void note_row(logic [2:0] row, logic [17:0] first, logic [17:0] second);
      logic [7:0] code;
      logic [kmh_pkg::OUT_W-1:0] report;
      bit changed;
      bit placed;
      if (row >= ROW_COUNT) return;
      if (row == 0) begin
        work_mods = '0;
        foreach (work_keys[s]) work_keys[s] = '0;
      end
      if (first != 0 && second != 0) begin
        for (int c = 0; c < COL_COUNT; c++) begin
          code = second[c] ? USAGE_MAP[row][c] : 8'h00;
          if (code >= MOD_LOW && code <= MOD_HIGH) begin
            work_mods[code - MOD_LOW] = 1'b1;
          end else if (code != 0) begin
            // first empty slot takes the key; dropped when all are full
            placed = 0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (!placed && work_keys[s] == 0) begin
                work_keys[s] = code;
                placed = 1;
              end
            end
          end
        end
      end
      if (row != ROW_COUNT - 1) return;
      // emit only when the report differs from the last one sent
      changed = (work_mods != sent_mods);
      for (int s = 0; s < SLOT_COUNT; s++) changed |= (work_keys[s] != sent_keys[s]);
      if (!changed) return;
      sent_mods = work_mods;
      report = '0;
      report[7:0] = work_mods;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        sent_keys[s] = work_keys[s];
        report[8*(s+1) +: 8] = work_keys[s];
      end
      pending_reports.push_back(report);
    endfunction

    // Compare one sent report with the oldest expected one
    function void check_report(logic [kmh_pkg::OUT_W-1:0] got);
      string names [7];
      logic [kmh_pkg::OUT_W-1:0] want;
      names = '{"modifier_bits", "key_one", "key_two", "key_three",
                "key_four", "key_five", "key_six"};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      for (int f = 0; f < 7; f++) begin
        if (got[8*f +: 8] !== want[8*f +: 8]) begin
          $display("%0t: %s expected %h actual %h", $time, names[f],
                   want[8*f +: 8], got[8*f +: 8]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // s_tdata: row_index, first_sample, second_sample
  logic [kmh_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // m_tdata: modifier_bits, key_one, key_two, key_three, key_four, key_five, key_six
  logic [kmh_pkg::OUT_W-1:0] m_tdata;

  hid_report_board board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int rows_sent = 0;
  int quiet_cycles = 0;
  logic [17:0] scan_first [ROW_COUNT];
  logic [17:0] scan_second [ROW_COUNT];

  key_matrix_to_hid_report u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Stall the report side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check each report transfer and watch for a hung handshake
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_report(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("key_matrix_to_hid_report: mismatch");
      $finish;
    end
  end

  // Present one row, hold it until the transfer, then predict
  task automatic send_row(logic [2:0] row, logic [17:0] first, logic [17:0] second);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, second, first, row};
    do @(posedge clk); while (!s_tready);
    board.note_row(row, first, second);
    if (row < ROW_COUNT) rows_sent++;
  endtask

  // Hold off the sender until every expected report has come
  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_reports.size() != 0);
  endtask

  // Mostly sparse column patterns, with empty, dense and full ones mixed in
  function automatic logic [17:0] pick_columns();
    int mode;
    logic [17:0] cols;
    mode = $urandom_range(0, 9);
    cols = '0;
    if (mode == 0) begin
      cols = '0;
    end else if (mode <= 4) begin
      cols[$urandom_range(0, COL_COUNT - 1)] = 1'b1;
    end else if (mode <= 7) begin
      repeat ($urandom_range(2, 4)) cols[$urandom_range(0, COL_COUNT - 1)] = 1'b1;
    end else if (mode == 8) begin
      cols = 18'($urandom);
    end else begin
      cols = ALL_COLUMNS;
    end
    return cols;
  endfunction

  // First sample decides only whether the row is used
  function automatic logic [17:0] pick_first(logic [17:0] second);
    int mode;
    logic [17:0] cols;
    mode = $urandom_range(0, 9);
    if (mode == 0) cols = '0;
    else if (mode <= 2) cols = 18'($urandom);
    else if (mode <= 7) cols = (second != 0) ? second : ALL_COLUMNS;
    else cols = pick_columns() | (18'd1 << $urandom_range(0, COL_COUNT - 1));
    return cols;
  endfunction

  // Random mix of full scans, broken scans and stray rows
  task automatic random_phase(int idle_pct, int stall);
    int limit;
    int kind;
    int depth;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    limit = rows_sent + ITEMS_PER_PHASE;
    while (rows_sent < limit) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // well-formed scan, sometimes a repeat of the last one
        if ($urandom_range(0, 99) >= 30) begin
          for (int r = 0; r < ROW_COUNT; r++) begin
            scan_second[r] = pick_columns();
            scan_first[r]  = pick_first(scan_second[r]);
          end
        end
        for (int r = 0; r < ROW_COUNT; r++) send_row(3'(r), scan_first[r], scan_second[r]);
      end else if (kind < 92) begin
        // truncated scan or rows in random order
        depth = $urandom_range(1, ROW_COUNT);
        for (int k = 0; k < depth; k++) begin
          if ($urandom_range(0, 1) == 1) begin
            send_row(3'(k), 18'($urandom), pick_columns());
          end else begin
            send_row(3'($urandom_range(0, 7)), pick_columns(), pick_columns());
          end
        end
      end else begin
        // stray row, often beyond the matrix
        send_row(3'($urandom_range(0, 7)), 18'($urandom), 18'($urandom));
      end
    end
  endtask

  initial begin
    foreach (scan_first[r]) begin
      scan_first[r]  = '0;
      scan_second[r] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // every column pressed: slots fill up, later keys dropped
    for (int r = 0; r < ROW_COUNT; r++) send_row(3'(r), ALL_COLUMNS, ALL_COLUMNS);
    // last row alone again: report unchanged, nothing sent
    send_row(3'd5, ALL_COLUMNS, ALL_COLUMNS);
    // one zero sample each: rows unused, empty report
    send_row(3'd0, 18'd0, ALL_COLUMNS);
    send_row(3'd5, ALL_COLUMNS, 18'd0);
    // rows beyond the matrix are dropped
    send_row(3'd6, ALL_COLUMNS, ALL_COLUMNS);
    send_row(3'd7, ALL_COLUMNS, ALL_COLUMNS);
    // same code twice fills two slots; top column of the last row
    send_row(3'd0, 18'd1, 18'h00042);
    send_row(3'd5, ALL_COLUMNS, 18'h20000);
    // keymap holes and modifier-only rows
    send_row(3'd0, 18'h10000, 18'h10000);
    send_row(3'd3, 18'h02000, 18'h02000);
    send_row(3'd4, 18'h00801, 18'h00801);
    send_row(3'd5, 18'h0006F, 18'h0006F);
    // single column extremes and alternating columns, rows in order
    send_row(3'd0, 18'h00001, 18'h00001);
    send_row(3'd1, 18'h20000, 18'h20000);
    send_row(3'd2, 18'h3FFFE, 18'h00001);
    send_row(3'd3, 18'h1FFFF, 18'h20000);
    send_row(3'd4, 18'h2AAAA, 18'h15555);
    send_row(3'd5, 18'h15555, 18'h2AAAA);
    wait_for_reports();

    random_phase(0, 0);
    wait_for_reports();
    random_phase(53, 0);
    wait_for_reports();
    random_phase(0, 53);
    wait_for_reports();
    random_phase(26, 26);
    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.pending_reports.size() != 0) begin
      $display("%0t: %0d expected reports never sent, oldest %h", $time,
               board.pending_reports.size(), board.pending_reports[0]);
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("key_matrix_to_hid_report: match");
    end else begin
      $display("key_matrix_to_hid_report: mismatch");
    end
    $finish;
  end

endmodule
